/* hdl/bdq_pkg.sv */
// shared types and constants for the bounded deque
package bdq_pkg;

    localparam int CAPACITY = 32;
    localparam int WORD_W   = 32;
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam logic [OP_W-1:0] OP_ADD_BACK     = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_FRONT    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP         = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PREV = 2'd1,
        CELL_NEXT = 2'd2,
        CELL_LOAD = 2'd3
    } cell_cmd_t;

    // chain movement requested by the controller for one cycle
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load_at_fill;
        logic rotate;
    } chain_ctl_t;

endpackage

/* hdl/bdq_cell.sv */
// one storage cell of the deque chain
module bdq_cell (
    input  logic                              clk,
    input  bdq_pkg::cell_cmd_t                cmd,
    input  logic signed [bdq_pkg::WORD_W-1:0] prev_word,
    input  logic signed [bdq_pkg::WORD_W-1:0] next_word,
    input  logic signed [bdq_pkg::WORD_W-1:0] load_word,
    output logic signed [bdq_pkg::WORD_W-1:0] word
);
    import bdq_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb
    begin
        case (cmd)
            CELL_HOLD: word_next = word_reg;
            CELL_PREV: word_next = prev_word;
            CELL_NEXT: word_next = next_word;
            CELL_LOAD: word_next = load_word;
            default:   word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* hdl/bdq_ctrl.sv */
// request decode, fill tracking, dump sequencing and result registers
module bdq_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [bdq_pkg::OP_W-1:0]            op,
    input  logic signed [bdq_pkg::WORD_W-1:0]   head_word,
    output logic                                busy,
    output bdq_pkg::chain_ctl_t                 ctl,
    output logic [bdq_pkg::FILL_W-1:0]          fill,
    output logic                                strobe,
    output logic [bdq_pkg::STATUS_W-1:0]        status,
    output logic signed [bdq_pkg::WORD_W-1:0]   data,
    output logic                                has_data,
    output logic [bdq_pkg::COUNT_W-1:0]         count,
    output logic                                last
);
    import bdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [FILL_W-1:0]     remain_reg, remain_next;
    logic                  strobe_reg, strobe_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic signed [WORD_W-1:0] data_reg, data_next;
    logic                  has_data_reg, has_data_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  last_reg, last_next;
    logic                  accept;
    logic                  is_full;
    logic                  is_empty;

    assign accept   = start && (state_reg == S_IDLE);
    assign is_full  = (fill_reg == FILL_W'(CAPACITY));
    assign is_empty = (fill_reg == '0);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        remain_next   = remain_reg;
        strobe_next   = 1'b0;
        status_next   = STATUS_OK;
        data_next     = '0;
        has_data_next = 1'b0;
        count_next    = COUNT_W'(fill_reg);
        last_next     = 1'b1;
        ctl           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    case (op)
                        OP_ADD_BACK:
                        begin
                            if (is_full)
                                status_next = STATUS_FULL;
                            else
                            begin
                                ctl.load_at_fill = 1'b1;
                                fill_next        = fill_reg + 1'b1;
                            end
                        end
                        OP_ADD_FRONT:
                        begin
                            if (is_full)
                                status_next = STATUS_FULL;
                            else
                            begin
                                ctl.shift_up = 1'b1;
                                fill_next    = fill_reg + 1'b1;
                            end
                        end
                        OP_REMOVE_BACK:
                        begin
                            if (is_empty)
                                status_next = STATUS_EMPTY;
                            else
                                fill_next = fill_reg - 1'b1;
                        end
                        OP_REMOVE_FRONT:
                        begin
                            if (is_empty)
                                status_next = STATUS_EMPTY;
                            else
                            begin
                                ctl.shift_down = 1'b1;
                                fill_next      = fill_reg - 1'b1;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (is_empty)
                                status_next = STATUS_EMPTY;
                            else
                            begin
                                // words come out of the chain from the next cycle on
                                strobe_next = 1'b0;
                                remain_next = fill_reg;
                                state_next  = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                    count_next = COUNT_W'(fill_next);
                end
            end
            S_DUMP:
            begin
                // emit the front cell and rotate it to the tail of the occupied part
                ctl.rotate    = 1'b1;
                strobe_next   = 1'b1;
                data_next     = head_word;
                has_data_next = 1'b1;
                last_next     = (remain_reg == FILL_W'(1));
                remain_next   = remain_reg - 1'b1;
                if (remain_reg == FILL_W'(1))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            remain_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        data_reg     <= data_next;
        has_data_reg <= has_data_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign fill     = fill_reg;
    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign data     = data_reg;
    assign has_data = has_data_reg;
    assign count    = count_reg;
    assign last     = last_reg;

endmodule

/* hdl/bounded_deque_unit.sv */
// top level of the bounded deque: controller and chain of storage cells
//
// channel   direction  handshake              payload
// request   in         start high, busy low   op, value
// result    out        strobe, one cycle      status, data, has_data, count, last
//
// add, remove, unused codes and a dump of an empty deque leave busy low; the result strobes the cycle after
// a dump of n words keeps busy high while its words are read, one word per cycle off the front
// cell while the occupied part of the chain rotates back into order
// reset clears the fill count and the dump state; cell contents are left as they are
// results cannot be stalled; a new request may be taken while the last result shows
module bounded_deque_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bdq_pkg::OP_W-1:0]            op,
    input  logic signed [bdq_pkg::WORD_W-1:0]   value,
    output logic                                strobe,
    output logic [bdq_pkg::STATUS_W-1:0]        status,
    output logic signed [bdq_pkg::WORD_W-1:0]   data,
    output logic                                has_data,
    output logic [bdq_pkg::COUNT_W-1:0]         count,
    output logic                                last
);
    import bdq_pkg::*;

    chain_ctl_t               ctl;
    logic [FILL_W-1:0]        fill;
    logic signed [WORD_W-1:0] word [CAPACITY];
    logic signed [WORD_W-1:0] load_word;
    cell_cmd_t                cmd [CAPACITY];

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .head_word (word[0]),
        .busy      (busy),
        .ctl       (ctl),
        .fill      (fill),
        .strobe    (strobe),
        .status    (status),
        .data      (data),
        .has_data  (has_data),
        .count     (count),
        .last      (last)
    );

    // during a dump the tail cell takes the front word, otherwise the new value
    assign load_word = ctl.rotate ? word[0] : value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] prev_word;
        logic signed [WORD_W-1:0] next_word;

        if (i == 0)
        begin : g_first
            assign prev_word = value;
        end
        else
        begin : g_mid_prev
            assign prev_word = word[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_word = word[i];
        end
        else
        begin : g_mid_next
            assign next_word = word[i+1];
        end

        always_comb
        begin
            cmd[i] = CELL_HOLD;
            if (ctl.shift_up)
                cmd[i] = (i == 0) ? CELL_LOAD : CELL_PREV;
            else if (ctl.load_at_fill)
                cmd[i] = (fill == FILL_W'(i)) ? CELL_LOAD : CELL_HOLD;
            else if (ctl.shift_down)
                cmd[i] = CELL_NEXT;
            else if (ctl.rotate)
            begin
                if (fill == FILL_W'(i + 1))
                    cmd[i] = CELL_LOAD;
                else if (fill > FILL_W'(i + 1))
                    cmd[i] = CELL_NEXT;
                else
                    cmd[i] = CELL_HOLD;
            end
        end

        bdq_cell u_cell (
            .clk       (clk),
            .cmd       (cmd[i]),
            .prev_word (prev_word),
            .next_word (next_word),
            .load_word (load_word),
            .word      (word[i])
        );
    end

endmodule

/* hdl/bdq_checker.sv */
// port-level checks on the bounded deque and their binding
module bdq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [bdq_pkg::OP_W-1:0]            op,
    input logic                                strobe,
    input logic [bdq_pkg::STATUS_W-1:0]        status,
    input logic signed [bdq_pkg::WORD_W-1:0]   data,
    input logic                                has_data,
    input logic [bdq_pkg::COUNT_W-1:0]         count,
    input logic                                last
);
    import bdq_pkg::*;

    // a word-carrying result is always an ok dump step
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && has_data |-> status == STATUS_OK)
        else $error("dump word with non-ok status");

    // status-only results are single and carry no word
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !has_data |-> last && data == '0)
        else $error("status result not last or data not zero");

    // non-dump requests answer in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op != OP_DUMP |=> strobe && last && !has_data)
        else $error("missing single result after request");

    // a dump that is not finished keeps streaming
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && has_data && !last |=> strobe && has_data)
        else $error("dump stream broken");

    // a refused add only happens at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == STATUS_FULL |-> count == COUNT_W'(CAPACITY))
        else $error("full status below capacity");

endmodule

bind bounded_deque_unit bdq_checker u_bdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .strobe   (strobe),
    .status   (status),
    .data     (data),
    .has_data (has_data),
    .count    (count),
    .last     (last)
);

/* tb/bounded_deque_unit_tb.sv */
// self-checking testbench for the bounded deque unit
module bounded_deque_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 480;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int GAP_PERCENT  = 31;

    typedef struct {
        logic [OP_W-1:0]   code;
        logic [WORD_W-1:0] word;
        bit                drain_first;
        bit                no_gap;
    } deque_request_t;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] data;
        logic                     has_data;
        logic [COUNT_W-1:0]       count;
        logic                     last;
    } deque_result_t;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     start    = 1'b0;
    logic [OP_W-1:0]          op       = OP_ADD_BACK;
    logic signed [WORD_W-1:0] value    = '0;
    logic                     busy;
    logic                     strobe;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] data;
    logic                     has_data;
    logic [COUNT_W-1:0]       count;
    logic                     last;

    deque_request_t pending_requests[$];
    deque_result_t  expected_results[$];

    // shadow copy of the deque
    logic [WORD_W-1:0] model_words [CAPACITY];
    int                model_head = 0;
    int                model_fill = 0;

    int mismatches   = 0;
    int stall_cycles = 0;

    bounded_deque_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .value    (value),
        .strobe   (strobe),
        .status   (status),
        .data     (data),
        .has_data (has_data),
        .count    (count),
        .last     (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic deque_result_t make_result(logic [STATUS_W-1:0] st,
                                                  logic [WORD_W-1:0] word,
                                                  logic carries, logic final_one);
        deque_result_t r;
        r.status   = st;
        r.data     = word;
        r.has_data = carries;
        r.count    = COUNT_W'(model_fill);
        r.last     = final_one;
        return r;
    endfunction

    // apply one request to the shadow deque and queue what it should produce
    task automatic predict_deque(logic [OP_W-1:0] code, logic [WORD_W-1:0] word);
        logic [STATUS_W-1:0] st;
        st = STATUS_OK;
        case (code)
            OP_ADD_BACK:
            begin
                if (model_fill >= CAPACITY)
                begin
                    st = STATUS_FULL;
                end
                else
                begin
                    model_words[(model_head + model_fill) % CAPACITY] = word;
                    model_fill++;
                end
            end
            OP_ADD_FRONT:
            begin
                if (model_fill >= CAPACITY)
                begin
                    st = STATUS_FULL;
                end
                else
                begin
                    model_head = (model_head + CAPACITY - 1) % CAPACITY;
                    model_words[model_head] = word;
                    model_fill++;
                end
            end
            OP_REMOVE_BACK:
            begin
                if (model_fill == 0)
                    st = STATUS_EMPTY;
                else
                    model_fill--;
            end
            OP_REMOVE_FRONT:
            begin
                if (model_fill == 0)
                begin
                    st = STATUS_EMPTY;
                end
                else
                begin
                    model_head = (model_head + 1) % CAPACITY;
                    model_fill--;
                end
            end
            OP_DUMP:
            begin
                if (model_fill == 0)
                    st = STATUS_EMPTY;
            end
            default:
            begin
            end
        endcase

        if (code == OP_DUMP && model_fill != 0)
        begin
            for (int i = 0; i < model_fill; i++)
            begin
                expected_results.push_back(make_result(STATUS_OK,
                    model_words[(model_head + i) % CAPACITY], 1'b1, i == model_fill - 1));
            end
        end
        else
        begin
            expected_results.push_back(make_result(st, '0, 1'b0, 1'b1));
        end
    endtask

    task automatic add_request(logic [OP_W-1:0] code, logic [WORD_W-1:0] word,
                               bit drain_first = 1'b0);
        deque_request_t r;
        r.code        = code;
        r.word        = word;
        r.drain_first = drain_first;
        // a calm stretch in the middle of the run with no random gaps
        r.no_gap      = pending_requests.size() >= 200 && pending_requests.size() < 300;
        pending_requests.push_back(r);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // driver: present the next request once the current one is taken
    always @(posedge clk)
    begin
        deque_request_t nxt;
        logic           launch;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_deque(op, value);
            end
            if (!(start && busy))
            begin
                launch = pending_requests.size() != 0;
                if (launch && pending_requests[0].drain_first && expected_results.size() != 0)
                    launch = 1'b0;
                if (launch && !pending_requests[0].no_gap
                    && $urandom_range(99) < GAP_PERCENT)
                    launch = 1'b0;
                if (launch)
                begin
                    nxt = pending_requests.pop_front();
                    start <= 1'b1;
                    op    <= nxt.code;
                    value <= nxt.word;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe must match the oldest expected result
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && strobe !== 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                note_mismatch("result with nothing pending", {status, data}, '0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    note_mismatch("status", status, want.status);
                if (data !== want.data)
                    note_mismatch("data", data, want.data);
                if (has_data !== want.has_data)
                    note_mismatch("has_data", has_data, want.has_data);
                if (count !== want.count)
                    note_mismatch("count", count, want.count);
                if (last !== want.last)
                    note_mismatch("last", last, want.last);
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe === 1'b1)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int directed;
        int kind;
        int len;
        int phase;
        logic [OP_W-1:0] code;

        // empty deque corners, unused codes, word extremes, dumps at several fills
        add_request(OP_DUMP, '0);
        add_request(OP_REMOVE_BACK, 32'hffff_ffff);
        add_request(OP_REMOVE_FRONT, '0);
        add_request(3'd5, 32'h1234_5678);
        add_request(OP_ADD_BACK, 32'h7fff_ffff);
        add_request(OP_ADD_FRONT, 32'h8000_0000);
        add_request(OP_ADD_BACK, 32'h0000_0000);
        add_request(OP_ADD_FRONT, 32'hffff_ffff);
        add_request(OP_ADD_BACK, 32'h5555_5555);
        add_request(OP_ADD_FRONT, 32'haaaa_aaaa);
        add_request(OP_DUMP, 32'hffff_ffff);
        add_request(3'd6, '0);
        add_request(3'd7, 32'hffff_ffff);
        add_request(OP_REMOVE_FRONT, '0);
        add_request(OP_REMOVE_BACK, '0);
        add_request(OP_DUMP, '0);
        add_request(OP_REMOVE_BACK, '0);
        add_request(OP_REMOVE_FRONT, '0);
        add_request(OP_DUMP, '0);
        add_request(OP_REMOVE_BACK, '0);
        add_request(OP_REMOVE_FRONT, '0);
        add_request(OP_REMOVE_FRONT, '0);
        add_request(OP_DUMP, '0);
        directed = pending_requests.size();

        // random part: fill runs to full, drain runs to empty, mixed noise and short dump bursts
        phase = 0;
        while (pending_requests.size() < directed + RANDOM_ITEMS)
        begin
            kind = $urandom_range(9);
            if (kind <= 2)
                len = $urandom_range(34, 38);
            else if (kind <= 5)
                len = $urandom_range(34, 38);
            else if (kind <= 8)
                len = $urandom_range(15, 30);
            else
                len = $urandom_range(2, 4);
            for (int i = 0; i < len; i++)
            begin
                if (kind <= 2)
                    code = ($urandom_range(11) == 0) ? OP_DUMP
                         : ($urandom_range(1) ? OP_ADD_FRONT : OP_ADD_BACK);
                else if (kind <= 5)
                    code = ($urandom_range(11) == 0) ? OP_DUMP
                         : ($urandom_range(1) ? OP_REMOVE_FRONT : OP_REMOVE_BACK);
                else if (kind <= 8)
                    code = ($urandom_range(19) == 0) ? OP_W'($urandom_range(5, 7))
                         : OP_W'($urandom_range(0, 4));
                else
                    code = OP_DUMP;
                add_request(code, pick_word(), i == 0 && phase % 4 == 0);
            end
            phase++;
        end

        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_requests.size() != 0 || start || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hdl/bdq_pkg.sv
hdl/bdq_cell.sv
hdl/bdq_ctrl.sv
hdl/bounded_deque_unit.sv
hdl/bdq_checker.sv
tb/bounded_deque_unit_tb.sv
